FILE: hdl/hsv565_pkg.sv
`timescale 1ns / 1ps

package hsv565_pkg;

   // hue sectors, named by the color at their start
   localparam logic [2:0] SECT_RED     = 3'd0;
   localparam logic [2:0] SECT_YELLOW  = 3'd1;
   localparam logic [2:0] SECT_GREEN   = 3'd2;
   localparam logic [2:0] SECT_CYAN    = 3'd3;
   localparam logic [2:0] SECT_BLUE    = 3'd4;
   localparam logic [2:0] SECT_MAGENTA = 3'd5;

   localparam logic [8:0]  TURN_DEG    = 9'd360;
   localparam logic [8:0]  SECTOR_SPAN = 9'd60;
   localparam logic [5:0]  SPAN_H      = 6'd60;
   localparam logic [7:0]  FULL_SCALE  = 8'd255;
   localparam logic [13:0] RATIO_DEN   = 14'd15300;

   // floor(x/360) = (x*HUE_RECIP) >> HUE_SHIFT, exact for any 16-bit x
   localparam logic [15:0] HUE_RECIP = 16'd46604;
   localparam int          HUE_SHIFT = 24;
   // floor(x/255) for x up to 255*255
   localparam logic [16:0] P_RECIP   = 17'd65794;
   localparam int          P_SHIFT   = 24;
   // floor(x/15300) for x up to 255*15300
   localparam logic [22:0] Q_RECIP   = 23'd4491470;
   localparam int          Q_SHIFT   = 36;

   typedef struct packed {
      logic [2:0] sector;
      logic [5:0] h;
      logic [7:0] sat;
      logic [7:0] bright;
   } split_type;

   typedef struct packed {
      logic [2:0] sector;
      logic [7:0] bright;
      logic [7:0] p;
      logic [7:0] q;
      logic [7:0] t;
   } level_type;

endpackage

FILE: hdl/hsv565_hue_split.sv
`timescale 1ns / 1ps

module hsv565_hue_split (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [15:0]           hue_deg,
   input  logic [7:0]            sat_level,
   input  logic [7:0]            bright_level,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hsv565_pkg::split_type out_data
);

   // stage 1: number of whole turns
   logic        s1_valid_ff, s1_valid_in, s1_ready;
   logic [15:0] s1_hue_ff;
   logic [7:0]  s1_quot_ff;
   logic [7:0]  s1_sat_ff, s1_bright_ff;
   logic [31:0] quot_prod;

   // stage 2: sector and remainder
   logic                  s2_valid_ff, s2_valid_in, s2_ready;
   hsv565_pkg::split_type s2_ff, s2_in;
   logic [16:0]           turn_sub;
   logic [8:0]            hue_red;
   logic [8:0]            sect_base;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign quot_prod   = 32'(hue_deg) * 32'(hsv565_pkg::HUE_RECIP);
   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (s1_ready) begin
         s1_hue_ff    <= hue_deg;
         s1_quot_ff   <= quot_prod[hsv565_pkg::HUE_SHIFT+7:hsv565_pkg::HUE_SHIFT];
         s1_sat_ff    <= sat_level;
         s1_bright_ff <= bright_level;
      end
   end

   assign turn_sub = 17'(s1_quot_ff) * 17'(hsv565_pkg::TURN_DEG);
   assign hue_red  = 9'(17'(s1_hue_ff) - turn_sub);

   always_comb begin
      s2_in.sat    = s1_sat_ff;
      s2_in.bright = s1_bright_ff;
      priority if (hue_red >= 9'(5 * hsv565_pkg::SECTOR_SPAN)) begin
         s2_in.sector = hsv565_pkg::SECT_MAGENTA;
         sect_base    = 9'(5 * hsv565_pkg::SECTOR_SPAN);
      end else if (hue_red >= 9'(4 * hsv565_pkg::SECTOR_SPAN)) begin
         s2_in.sector = hsv565_pkg::SECT_BLUE;
         sect_base    = 9'(4 * hsv565_pkg::SECTOR_SPAN);
      end else if (hue_red >= 9'(3 * hsv565_pkg::SECTOR_SPAN)) begin
         s2_in.sector = hsv565_pkg::SECT_CYAN;
         sect_base    = 9'(3 * hsv565_pkg::SECTOR_SPAN);
      end else if (hue_red >= 9'(2 * hsv565_pkg::SECTOR_SPAN)) begin
         s2_in.sector = hsv565_pkg::SECT_GREEN;
         sect_base    = 9'(2 * hsv565_pkg::SECTOR_SPAN);
      end else if (hue_red >= hsv565_pkg::SECTOR_SPAN) begin
         s2_in.sector = hsv565_pkg::SECT_YELLOW;
         sect_base    = hsv565_pkg::SECTOR_SPAN;
      end else begin
         s2_in.sector = hsv565_pkg::SECT_RED;
         sect_base    = 9'd0;
      end
      s2_in.h = 6'(hue_red - sect_base);
   end

   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

   // the reciprocal quotient must give a remainder in 0..359
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (turn_sub <= 17'(s1_hue_ff)) &&
                      ((17'(s1_hue_ff) - turn_sub) < 17'(hsv565_pkg::TURN_DEG)))
      else $error("hue reduction out of range");

   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_ff.h < hsv565_pkg::SPAN_H) &&
                      (s2_ff.sector <= hsv565_pkg::SECT_MAGENTA))
      else $error("sector split out of range");

endmodule

FILE: hdl/hsv565_level_calc.sv
`timescale 1ns / 1ps

module hsv565_level_calc (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hsv565_pkg::split_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hsv565_pkg::level_type out_data
);

   // stage 3: numerators
   logic        s3_valid_ff, s3_valid_in, s3_ready;
   logic [2:0]  s3_sector_ff;
   logic [7:0]  s3_bright_ff;
   logic [7:0]  s3_num_p_ff;
   logic [13:0] s3_num_q_ff, s3_num_t_ff;
   logic [5:0]  span_left;
   logic [13:0] sh_q, sh_t;

   // stage 4: level times numerator
   logic        s4_valid_ff, s4_valid_in, s4_ready;
   logic [2:0]  s4_sector_ff;
   logic [7:0]  s4_bright_ff;
   logic [15:0] s4_prod_p_ff;
   logic [21:0] s4_prod_q_ff, s4_prod_t_ff;

   // stage 5: divide by the denominators through reciprocals
   logic                  s5_valid_ff, s5_valid_in, s5_ready;
   hsv565_pkg::level_type s5_ff, s5_in;
   logic [32:0]           div_p;
   logic [44:0]           div_q, div_t;

   assign s5_ready = !s5_valid_ff || out_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign in_ready = s3_ready;

   assign span_left = hsv565_pkg::SPAN_H - in_data.h;
   assign sh_q      = 14'(in_data.sat) * 14'(in_data.h);
   assign sh_t      = 14'(in_data.sat) * 14'(span_left);

   assign s3_valid_in = s3_ready ? in_valid : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
      if (s3_ready) begin
         s3_sector_ff <= in_data.sector;
         s3_bright_ff <= in_data.bright;
         s3_num_p_ff  <= hsv565_pkg::FULL_SCALE - in_data.sat;
         s3_num_q_ff  <= hsv565_pkg::RATIO_DEN - sh_q;
         s3_num_t_ff  <= hsv565_pkg::RATIO_DEN - sh_t;
      end
   end

   assign s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
      end
      if (s4_ready) begin
         s4_sector_ff <= s3_sector_ff;
         s4_bright_ff <= s3_bright_ff;
         s4_prod_p_ff <= 16'(s3_bright_ff) * 16'(s3_num_p_ff);
         s4_prod_q_ff <= 22'(s3_bright_ff) * 22'(s3_num_q_ff);
         s4_prod_t_ff <= 22'(s3_bright_ff) * 22'(s3_num_t_ff);
      end
   end

   assign div_p = 33'(s4_prod_p_ff) * 33'(hsv565_pkg::P_RECIP);
   assign div_q = 45'(s4_prod_q_ff) * 45'(hsv565_pkg::Q_RECIP);
   assign div_t = 45'(s4_prod_t_ff) * 45'(hsv565_pkg::Q_RECIP);

   always_comb begin
      s5_in.sector = s4_sector_ff;
      s5_in.bright = s4_bright_ff;
      s5_in.p      = div_p[hsv565_pkg::P_SHIFT+7:hsv565_pkg::P_SHIFT];
      s5_in.q      = div_q[hsv565_pkg::Q_SHIFT+7:hsv565_pkg::Q_SHIFT];
      s5_in.t      = div_t[hsv565_pkg::Q_SHIFT+7:hsv565_pkg::Q_SHIFT];
   end

   assign s5_valid_in = s5_ready ? s4_valid_ff : s5_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s5_valid_in;
      end
      if (s5_ready) begin
         s5_ff <= s5_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_data  = s5_ff;

   // no helper level can exceed the value itself
   assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |-> (s5_ff.p <= s5_ff.bright) && (s5_ff.q <= s5_ff.bright) &&
                      (s5_ff.t <= s5_ff.bright))
      else $error("helper level above value");

endmodule

FILE: hdl/hsv_to_rgb565_converter.sv
`timescale 1ns / 1ps

// HSV to RGB565 converter. Every request carries a 16-bit hue in degrees (taken modulo 360),
// an 8-bit saturation and an 8-bit value, and gives one packed color (red 15..11, green 10..5,
// blue 4..0). The block is a six-stage pipeline: a request passes the registers of stages 1 to
// 5 and the response register before the color shows on rsp_, and a new request is taken every
// cycle as long as rsp_ready keeps up. Throughput is one request per clock while rsp_ready keeps
// up; the longest stage is the 22 x 23 bit reciprocal multiply that stands in for the divide by
// 15300. Back-pressure stalls the pipeline stage by stage, empty stages still fill, and nothing
// is lost or repeated. There are no registers to program; reset only empties the pipeline.
module hsv_to_rgb565_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_hue_deg,
   input  logic [7:0]  req_sat_level,
   input  logic [7:0]  req_bright_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_rgb565_color
);

   logic                  split_valid, split_ready;
   hsv565_pkg::split_type split_data;
   logic                  level_valid, level_ready;
   hsv565_pkg::level_type level_data;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_color_ff, rsp_color_in;
   logic [7:0]  red, green, blue;

   hsv565_hue_split u_split (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .hue_deg      (req_hue_deg),
      .sat_level    (req_sat_level),
      .bright_level (req_bright_level),
      .out_valid    (split_valid),
      .out_ready    (split_ready),
      .out_data     (split_data)
   );

   hsv565_level_calc u_level (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_data   (split_data),
      .out_valid (level_valid),
      .out_ready (level_ready),
      .out_data  (level_data)
   );

   assign level_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (level_data.sector)
         hsv565_pkg::SECT_RED: begin
            red = level_data.bright; green = level_data.t; blue = level_data.p;
         end
         hsv565_pkg::SECT_YELLOW: begin
            red = level_data.q; green = level_data.bright; blue = level_data.p;
         end
         hsv565_pkg::SECT_GREEN: begin
            red = level_data.p; green = level_data.bright; blue = level_data.t;
         end
         hsv565_pkg::SECT_CYAN: begin
            red = level_data.p; green = level_data.q; blue = level_data.bright;
         end
         hsv565_pkg::SECT_BLUE: begin
            red = level_data.t; green = level_data.p; blue = level_data.bright;
         end
         default: begin
            red = level_data.bright; green = level_data.p; blue = level_data.q;
         end
      endcase
      rsp_color_in = {red[7:3], green[7:2], blue[7:3]};
   end

   assign rsp_valid_in = level_ready ? level_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (level_ready) begin
         rsp_color_ff <= rsp_color_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rgb565_color = rsp_color_ff;

   // the pipeline is empty right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid_ff)
      else $error("response valid right after reset");

endmodule
